[rtl/srt_pkg.sv]
// Shared types and constants for the segment range table.
// Depends on nothing; every other file of the block imports it.
package srt_pkg;

    localparam int ADDR_BITS   = 48;
    localparam int HANDLE_BITS = 8;
    localparam int RESULT_HANDLE_BITS = 7;

    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;

    typedef enum logic [1:0] {
        ACT_REGISTER   = 2'd0,
        ACT_UNREGISTER = 2'd1,
        ACT_UPDATE     = 2'd2,
        ACT_LOOKUP     = 2'd3
    } srt_action_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FULL       = 2'd1,
        STATUS_BAD_HANDLE = 2'd2
    } srt_status_t;

    typedef enum logic {
        SRT_IDLE = 1'b0,
        SRT_EVAL = 1'b1
    } srt_state_t;

    // Input beat.
    typedef struct packed {
        srt_action_t action;
        handle_t     seg_handle;
        addr_t       mem_base;
        addr_t       alloc_offset;
        addr_t       commit_offset;
        addr_t       reserve_offset;
        addr_t       new_allocated;
        addr_t       new_committed;
        addr_t       query_addr;
    } srt_item_t;

    // Result beat.
    typedef struct packed {
        logic [RESULT_HANDLE_BITS-1:0] result_handle;
        logic                          in_segment;
        srt_status_t                   status;
    } srt_result_t;

    // Command broadcast to every cell during evaluation.
    typedef struct packed {
        logic        eval;
        srt_action_t action;
        handle_t     seg_handle;
        addr_t       base;
        addr_t       alloc_end;
        addr_t       commit_end;
        addr_t       reserve_end;
        addr_t       query;
    } srt_cmd_t;

    // Values rippled from each cell to the next one up the row.
    typedef struct packed {
        logic    free_seen;
        logic    hit;
        handle_t handle;
    } srt_chain_t;

endpackage

[rtl/segment_range_table.sv]
// Segment range table: a row of TABLE_ENTRIES cells with one command at a time.
// A command accepted in the idle state moves the sequencer to evaluation, and its result
// strobe is registered as it leaves that state. Evaluation across the cell row holds
// busy, and the next command is taken while the result is shown.
// Reset clears all in-use marks at once; the receiver cannot stall results.
module segment_range_table
    import srt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  srt_item_t   item,
    output logic        result_valid,
    output srt_result_t result
);

    srt_state_t  state_reg, state_next;
    srt_action_t action_reg;
    handle_t     handle_reg;
    logic        handle_ok_reg;
    addr_t       base_reg, alloc_reg, commit_reg, reserve_reg, query_reg;

    logic        result_valid_reg, result_valid_next;
    srt_result_t result_reg, result_next;

    srt_cmd_t    cmd;
    srt_chain_t  chain [0:TABLE_ENTRIES];

    logic accept;

    assign accept       = start && (state_reg == SRT_IDLE);
    assign busy         = (state_reg == SRT_EVAL);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Latch the command; the register ends are summed here, wrapping at the address width.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg    <= item.action;
            handle_reg    <= item.seg_handle;
            handle_ok_reg <= (item.seg_handle != '0)
                             && (item.seg_handle <= HANDLE_BITS'(TABLE_ENTRIES));
            base_reg      <= item.mem_base;
            query_reg     <= item.query_addr;
            if (item.action == ACT_UPDATE)
            begin
                alloc_reg  <= item.new_allocated;
                commit_reg <= item.new_committed;
            end
            else
            begin
                alloc_reg  <= item.mem_base + item.alloc_offset;
                commit_reg <= item.mem_base + item.commit_offset;
            end
            reserve_reg   <= item.mem_base + item.reserve_offset;
        end
    end

    // Command broadcast to the cells.
    always_comb
    begin
        cmd.eval        = (state_reg == SRT_EVAL);
        cmd.action      = action_reg;
        cmd.seg_handle  = handle_reg;
        cmd.base        = base_reg;
        cmd.alloc_end   = alloc_reg;
        cmd.commit_end  = commit_reg;
        cmd.reserve_end = reserve_reg;
        cmd.query       = query_reg;
    end

    // The row of cells, lowest index first.
    assign chain[0] = '{free_seen: 1'b0, hit: 1'b0, handle: '0};

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        srt_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // Sequencer and result formation.
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        unique case (state_reg)
            SRT_IDLE:
            begin
                if (accept)
                begin
                    state_next = SRT_EVAL;
                end
            end
            SRT_EVAL:
            begin
                state_next                = SRT_IDLE;
                result_valid_next         = 1'b1;
                result_next.result_handle = '0;
                result_next.in_segment    = 1'b0;
                result_next.status        = STATUS_OK;
                unique case (action_reg)
                    ACT_REGISTER:
                    begin
                        if (chain[TABLE_ENTRIES].free_seen)
                        begin
                            result_next.result_handle =
                                chain[TABLE_ENTRIES].handle[RESULT_HANDLE_BITS-1:0];
                        end
                        else
                        begin
                            result_next.status = STATUS_FULL;
                        end
                    end
                    ACT_UNREGISTER, ACT_UPDATE:
                    begin
                        if (!handle_ok_reg)
                        begin
                            result_next.status = STATUS_BAD_HANDLE;
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        result_next.in_segment = chain[TABLE_ENTRIES].hit;
                    end
                    default:
                    begin
                        result_next.status = STATUS_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = SRT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= SRT_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

[rtl/srt_cell.sv]
// One entry of the segment range table: in-use mark, base and three ends.
// Depends on srt_pkg; chained by segment_range_table from low to high index.
module srt_cell
    import srt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  srt_cmd_t   cmd,
    input  srt_chain_t chain_in,
    output srt_chain_t chain_out
);

    localparam handle_t MY_HANDLE = HANDLE_BITS'(IDX + 1);

    logic  in_use_reg, in_use_next;
    addr_t base_reg, alloc_end_reg, commit_end_reg, reserve_end_reg;

    logic free_here, claim, handle_sel, hit_here, write_ends;

    // Local decisions and the chain to the next cell.
    always_comb
    begin
        free_here  = !in_use_reg;
        claim      = cmd.eval && (cmd.action == ACT_REGISTER) && free_here
                     && !chain_in.free_seen;
        handle_sel = (cmd.seg_handle == MY_HANDLE);
        hit_here   = in_use_reg && (cmd.query >= base_reg) && (cmd.query < commit_end_reg);
        write_ends = claim || (cmd.eval && (cmd.action == ACT_UPDATE) && handle_sel);

        chain_out.free_seen = chain_in.free_seen || free_here;
        chain_out.hit       = chain_in.hit || hit_here;
        chain_out.handle    = chain_in.handle | (claim ? MY_HANDLE : '0);

        in_use_next = in_use_reg;
        if (claim)
        begin
            in_use_next = 1'b1;
        end
        else if (cmd.eval && (cmd.action == ACT_UNREGISTER) && handle_sel)
        begin
            in_use_next = 1'b0;
        end
    end

    // The in-use mark is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
        end
    end

    // Segment bounds hold no reset value.
    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            base_reg        <= cmd.base;
            reserve_end_reg <= cmd.reserve_end;
        end
        if (write_ends)
        begin
            alloc_end_reg  <= cmd.alloc_end;
            commit_end_reg <= cmd.commit_end;
        end
    end

endmodule

[rtl/srt_checker.sv]
// Port-level checks for segment_range_table, attached by the bind below.
// Depends on srt_pkg and on the top level's port list.
module srt_checker
    import srt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input srt_result_t result
);

    // An accepted beat occupies the table for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // Every evaluation cycle is followed by exactly one result strobe.
    a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (result_valid == $past(busy)))
        else $error("result strobe does not follow evaluation");

    // Busy drops as soon as evaluation ends.
    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // A full table never hands out a handle.
    a_full_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == STATUS_FULL)) |-> (result.result_handle == '0))
        else $error("handle given with table full");

    // A lookup hit reports no handle and ok status.
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.in_segment)
            |-> ((result.status == STATUS_OK) && (result.result_handle == '0)))
        else $error("lookup hit carries handle or error status");

endmodule

bind segment_range_table srt_checker u_srt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

[bench/srt_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the segment range table bench: a software copy of the table
// that predicts each result beat and checks the beats that the block returns.
// Depends on srt_pkg for the beat types and the action and status codes.
package srt_tb_pkg;

    import srt_pkg::*;

    localparam int TB_ENTRIES   = 64;
    localparam int REPORT_LIMIT = 10;

    class segment_table_tracker;

        // Shadow copy of the table.
        bit    live[TB_ENTRIES];
        addr_t seg_base[TB_ENTRIES];
        addr_t seg_alloc_end[TB_ENTRIES];
        addr_t seg_commit_end[TB_ENTRIES];
        addr_t seg_reserve_end[TB_ENTRIES];

        // Result beats owed by the block, oldest first.
        srt_result_t awaited_results[$];

        int commands_seen;
        int mismatches;
        int full_refusals;
        int lookup_hits;
        int bad_handles;
        int action_count[4];

        // A handle names an entry when it lies in 1..TB_ENTRIES.
        function bit handle_ok(handle_t h);
            return h != '0 && h <= TB_ENTRIES;
        endfunction

        // Apply one accepted command beat to the shadow table and queue its result.
        function void note_command(srt_item_t cmd);
            srt_result_t outcome;
            int          idx;
            bit          placed;
            outcome        = '0;
            outcome.status = STATUS_OK;
            placed         = 1'b0;
            commands_seen++;
            action_count[int'(cmd.action)]++;
            case (cmd.action)
                ACT_REGISTER:
                begin
                    // The lowest free entry is taken; ends wrap at the address width.
                    outcome.status = STATUS_FULL;
                    for (int i = 0; i < TB_ENTRIES; i++)
                    begin
                        if (!placed && !live[i])
                        begin
                            placed                = 1'b1;
                            live[i]               = 1'b1;
                            seg_base[i]           = cmd.mem_base;
                            seg_alloc_end[i]      = cmd.mem_base + cmd.alloc_offset;
                            seg_commit_end[i]     = cmd.mem_base + cmd.commit_offset;
                            seg_reserve_end[i]    = cmd.mem_base + cmd.reserve_offset;
                            outcome.result_handle = RESULT_HANDLE_BITS'(i + 1);
                            outcome.status        = STATUS_OK;
                        end
                    end
                    if (!placed)
                        full_refusals++;
                end
                ACT_UNREGISTER:
                begin
                    if (handle_ok(cmd.seg_handle))
                    begin
                        idx       = int'(cmd.seg_handle) - 1;
                        live[idx] = 1'b0;
                    end
                    else
                    begin
                        outcome.status = STATUS_BAD_HANDLE;
                        bad_handles++;
                    end
                end
                ACT_UPDATE:
                begin
                    // Free entries get their ends written too and stay free.
                    if (handle_ok(cmd.seg_handle))
                    begin
                        idx                 = int'(cmd.seg_handle) - 1;
                        seg_alloc_end[idx]  = cmd.new_allocated;
                        seg_commit_end[idx] = cmd.new_committed;
                    end
                    else
                    begin
                        outcome.status = STATUS_BAD_HANDLE;
                        bad_handles++;
                    end
                end
                ACT_LOOKUP:
                begin
                    // Hit when the address lies in [base, committed end) of a live entry.
                    for (int i = 0; i < TB_ENTRIES; i++)
                    begin
                        if (live[i] && cmd.query_addr >= seg_base[i]
                            && cmd.query_addr < seg_commit_end[i])
                            outcome.in_segment = 1'b1;
                    end
                    if (outcome.in_segment)
                        lookup_hits++;
                end
            endcase
            awaited_results.push_back(outcome);
        endfunction

        // Compare one result beat with the oldest one owed.
        function void check_result(srt_result_t got);
            srt_result_t want;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result beat with none owed: handle %0d in_segment %0d status %0d",
                             $time, got.result_handle, got.in_segment, got.status);
                return;
            end
            want = awaited_results.pop_front();
            if (got.result_handle !== want.result_handle || got.in_segment !== want.in_segment
                || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result mismatch: handle %0d/%0d in_segment %0d/%0d status %0d/%0d (expected/actual)",
                             $time, want.result_handle, got.result_handle,
                             want.in_segment, got.in_segment, want.status, got.status);
            end
        endfunction

    endclass

endpackage

[bench/segment_range_table_tb.sv]
`timescale 1ns / 100ps
// Top of the segment range table bench: clock, reset, command driver, result
// monitor and watchdog. Depends on srt_pkg, srt_tb_pkg and segment_range_table.
module segment_range_table_tb;

    import srt_pkg::*;
    import srt_tb_pkg::*;

    typedef enum int {
        MIX_FILL,
        MIX_CHURN,
        MIX_DRAIN
    } mix_t;

    localparam int    PHASES      = 7;
    localparam int    PHASE_ITEMS = 146;
    localparam int    CALM_ITEMS  = 30;
    localparam int    STALL_LIMIT = 2000;
    localparam addr_t ADDR_TOP    = '1;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    srt_item_t   item;
    logic        result_valid;
    srt_result_t result;

    segment_table_tracker tracker;
    int                   idle_cycles = 0;
    bit                   calm_stretch = 1'b0;

    segment_range_table #(
        .TABLE_ENTRIES(TB_ENTRIES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Score the beats that cross the ports at each edge; count quiet cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                tracker.check_result(result);
            if (start && !busy)
                tracker.note_command(item);
            if (result_valid || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // End the run if nothing moves for too long.
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("segment_range_table verification failed");
        $finish;
    end

    function automatic addr_t rand_addr();
        return addr_t'({$urandom, $urandom});
    endfunction

    // Mostly short offsets, some zero, some across the whole address space.
    function automatic addr_t pick_offset();
        int roll;
        roll = $urandom_range(19);
        if (roll < 3)
            return '0;
        if (roll < 16)
            return addr_t'($urandom_range(4096));
        return rand_addr();
    endfunction

    // Random index of a live entry, or -1 when the table is empty.
    function automatic int pick_live();
        int found[$];
        for (int i = 0; i < TB_ENTRIES; i++)
            if (tracker.live[i])
                found.push_back(i);
        if (found.size() == 0)
            return -1;
        return found[$urandom_range(found.size() - 1)];
    endfunction

    // Most gaps are short; a few are long.
    function automatic int draw_gap();
        int roll;
        if (calm_stretch)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Command beat with every field random except the action.
    function automatic srt_item_t fresh_item(srt_action_t act);
        srt_item_t cmd;
        cmd.action         = act;
        cmd.seg_handle     = handle_t'($urandom);
        cmd.mem_base       = rand_addr();
        cmd.alloc_offset   = rand_addr();
        cmd.commit_offset  = rand_addr();
        cmd.reserve_offset = rand_addr();
        cmd.new_allocated  = rand_addr();
        cmd.new_committed  = rand_addr();
        cmd.query_addr     = rand_addr();
        return cmd;
    endfunction

    // Offer one beat after a random gap and wait until the block takes it.
    task automatic send_item(input srt_item_t cmd);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item  <= cmd;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_register(input addr_t base, input addr_t alloc_off,
                                 input addr_t commit_off, input addr_t reserve_off);
        srt_item_t cmd;
        cmd                = fresh_item(ACT_REGISTER);
        cmd.mem_base       = base;
        cmd.alloc_offset   = alloc_off;
        cmd.commit_offset  = commit_off;
        cmd.reserve_offset = reserve_off;
        send_item(cmd);
    endtask

    task automatic send_unregister(input handle_t h);
        srt_item_t cmd;
        cmd            = fresh_item(ACT_UNREGISTER);
        cmd.seg_handle = h;
        send_item(cmd);
    endtask

    task automatic send_update(input handle_t h, input addr_t alloc_end, input addr_t commit_end);
        srt_item_t cmd;
        cmd               = fresh_item(ACT_UPDATE);
        cmd.seg_handle    = h;
        cmd.new_allocated = alloc_end;
        cmd.new_committed = commit_end;
        send_item(cmd);
    endtask

    task automatic send_lookup(input addr_t addr);
        srt_item_t cmd;
        cmd            = fresh_item(ACT_LOOKUP);
        cmd.query_addr = addr;
        send_item(cmd);
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.awaited_results.size() != 0);
    endtask

    // Edges of ranges, wrapping ends, bad and free handles, entry reuse.
    task automatic run_directed();
        send_lookup('0);
        send_register('0, addr_t'(8), addr_t'(16), addr_t'(32));
        send_lookup('0);
        send_lookup(addr_t'(15));
        send_lookup(addr_t'(16));
        // Committed end wraps below the base: an empty range.
        send_register(ADDR_TOP, ADDR_TOP, addr_t'(2), ADDR_TOP);
        send_lookup(ADDR_TOP);
        send_register(addr_t'(100), addr_t'(50), '0, addr_t'(200));
        send_lookup(addr_t'(100));
        send_unregister('0);
        send_update('0, addr_t'(1), addr_t'(2));
        send_unregister(handle_t'(TB_ENTRIES + 1));
        send_update('1, addr_t'(1), addr_t'(2));
        // Last entry is still free here.
        send_unregister(handle_t'(TB_ENTRIES));
        send_update(handle_t'(TB_ENTRIES), addr_t'(500), addr_t'(1000));
        send_update(handle_t'(1), '0, addr_t'(40));
        send_lookup(addr_t'(39));
        send_unregister(handle_t'(1));
        send_lookup(addr_t'(5));
        // Reuses the first entry.
        send_register(addr_t'(1) << (ADDR_BITS - 1), '0, ADDR_TOP, addr_t'(1));
        send_lookup(addr_t'(1) << (ADDR_BITS - 1));
        send_register(ADDR_TOP - addr_t'(15), addr_t'(4), addr_t'(8), addr_t'(12));
        send_lookup(ADDR_TOP - addr_t'(9));
    endtask

    // Random command shaped toward live handles and the edges of live ranges.
    function automatic srt_item_t random_command(mix_t mix);
        srt_item_t   cmd;
        srt_action_t act;
        int          roll;
        int          pick;
        int          idx;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:
                act = roll < 65 ? ACT_REGISTER : roll < 72 ? ACT_UNREGISTER :
                      roll < 82 ? ACT_UPDATE : ACT_LOOKUP;
            MIX_CHURN:
                act = roll < 25 ? ACT_REGISTER : roll < 45 ? ACT_UNREGISTER :
                      roll < 65 ? ACT_UPDATE : ACT_LOOKUP;
            default:
                act = roll < 8 ? ACT_REGISTER : roll < 58 ? ACT_UNREGISTER :
                      roll < 70 ? ACT_UPDATE : ACT_LOOKUP;
        endcase
        cmd  = fresh_item(act);
        pick = pick_live();
        case (act)
            ACT_REGISTER:
            begin
                roll = $urandom_range(9);
                if (roll < 4)
                    cmd.mem_base = addr_t'($urandom_range(1 << 20));
                else if (roll < 6)
                    cmd.mem_base = ADDR_TOP - addr_t'($urandom_range(4096));
                cmd.commit_offset = pick_offset();
            end
            ACT_UNREGISTER, ACT_UPDATE:
            begin
                roll = $urandom_range(99);
                if (roll < 75 && pick >= 0)
                    cmd.seg_handle = handle_t'(pick + 1);
                else if (roll < 88)
                    cmd.seg_handle = handle_t'($urandom_range(TB_ENTRIES, 1));
                else if ($urandom_range(1) != 0)
                    cmd.seg_handle = '0;
                else
                    cmd.seg_handle = handle_t'($urandom_range(255, TB_ENTRIES + 1));
                // Keep most updates of live entries near their own base.
                if (act == ACT_UPDATE && tracker.handle_ok(cmd.seg_handle)
                    && $urandom_range(3) != 0)
                begin
                    idx = int'(cmd.seg_handle) - 1;
                    if (tracker.live[idx])
                    begin
                        cmd.new_allocated = tracker.seg_base[idx] + pick_offset();
                        cmd.new_committed = tracker.seg_base[idx] + pick_offset();
                    end
                end
            end
            ACT_LOOKUP:
            begin
                roll = $urandom_range(9);
                if (pick >= 0 && roll < 7)
                begin
                    case ($urandom_range(4))
                        0: cmd.query_addr = tracker.seg_base[pick] - addr_t'(1);
                        1: cmd.query_addr = tracker.seg_base[pick];
                        2: cmd.query_addr = tracker.seg_commit_end[pick] - addr_t'(1);
                        3: cmd.query_addr = tracker.seg_commit_end[pick];
                        default:
                            cmd.query_addr = tracker.seg_base[pick]
                                             + addr_t'($urandom_range(4096));
                    endcase
                end
                else if (roll < 8)
                    cmd.query_addr = addr_t'($urandom_range(1 << 20));
            end
        endcase
        return cmd;
    endfunction

    // One phase of random traffic; the first stretch runs without gaps.
    task automatic run_phase(input mix_t mix);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            calm_stretch = (n < CALM_ITEMS);
            send_item(random_command(mix));
        end
        calm_stretch = 1'b0;
        drain_results();
    endtask

    initial
    begin
        tracker = new;
        rst_n <= 1'b0;
        start <= 1'b0;
        item  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int p = 0; p < PHASES; p++)
            run_phase(mix_t'(p % 3));

        // Let the last beats come back, then check that none is still owed.
        drain_results();
        repeat (6) @(posedge clk);
        if (tracker.awaited_results.size() != 0)
        begin
            $display("%0d result beats never arrived", tracker.awaited_results.size());
            tracker.mismatches += tracker.awaited_results.size();
        end

        $display("Sent %0d commands: %0d register, %0d unregister, %0d update, %0d lookup.",
                 tracker.commands_seen, tracker.action_count[int'(ACT_REGISTER)],
                 tracker.action_count[int'(ACT_UNREGISTER)],
                 tracker.action_count[int'(ACT_UPDATE)],
                 tracker.action_count[int'(ACT_LOOKUP)]);
        $display("Saw %0d full-table refusals, %0d lookup hits, %0d bad handles, %0d mismatches.",
                 tracker.full_refusals, tracker.lookup_hits, tracker.bad_handles,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("segment_range_table verification clean");
        else
            $display("segment_range_table verification failed");
        $finish;
    end

endmodule
